FILE: hw/rtl/momentum_sgd_weight_updater_unit_defines.svh
// assertion macros for the momentum sgd weight updater
// included by the checker module; needs nothing else
`ifndef MOMENTUM_SGD_WEIGHT_UPDATER_UNIT_DEFINES_SVH
`define MOMENTUM_SGD_WEIGHT_UPDATER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define MSGD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define MSGD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds through reset
`define MSGD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/msgd_pkg.sv
// shared types and constants of the momentum sgd weight updater
// used by the top level and its checker; no dependencies
package msgd_pkg;

  // store geometry
  localparam int NUM_WEIGHTS = 4096;
  localparam int ADDR_W      = $clog2(NUM_WEIGHTS);

  // field widths
  localparam int INDEX_W     = 12;
  localparam int WORD_W      = 32;
  localparam int CFG_INDEX_W = 2;

  // stream bus widths
  localparam int IN_DATA_W   = 112;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 112;
  localparam int OUT_USER_W  = 2;

  // input tdata layout
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_GRAD_LSB = IN_IDX_LSB + INDEX_W;
  localparam int IN_LOAD_LSB = IN_GRAD_LSB + WORD_W;
  localparam int IN_ERR_LSB  = IN_LOAD_LSB + WORD_W;

  // output tdata layout
  localparam int OUT_IDX_LSB    = 0;
  localparam int OUT_WEIGHT_LSB = OUT_IDX_LSB + INDEX_W;
  localparam int OUT_UPDATE_LSB = OUT_WEIGHT_LSB + WORD_W;
  localparam int OUT_RATE_LSB   = OUT_UPDATE_LSB + WORD_W;
  localparam int OUT_PAD_W      = OUT_DATA_W - (OUT_RATE_LSB + WORD_W);

  // output tuser bits
  localparam int USER_CUT_BIT = 0;
  localparam int USER_SAT_BIT = 1;

  // item kinds
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_EPOCH = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INIT_RATE = 2'd0,
    CFG_DECREASE  = 2'd1,
    CFG_MOMENTUM  = 2'd2
  } cfg_reg_t;

  // reset values
  localparam logic [WORD_W-1:0] RATE_RESET     = 32'd26843546;
  localparam logic [WORD_W-1:0] DECR_RESET     = 32'd3006477107;
  localparam logic [WORD_W-1:0] MOMENTUM_RESET = 32'd0;
  localparam logic [WORD_W-1:0] ERROR_START    = 32'd655360;   // 10.0 in Q16.16

  // growth factor 1 + (1 - decrease) / 10 in Q1.32
  // numerator is 2^32 - decrease + 5 so the quotient rounds half up
  localparam logic [WORD_W:0] ND_RESET  = 33'(64'h1_0000_0000 - 64'(DECR_RESET) + 64'd5);
  localparam logic [WORD_W:0] FUP_RESET = {1'b1, 32'(ND_RESET / 10)};

  // divide by ten: multiply by ceil(2^36 / 10), exact for 33-bit numerators
  localparam logic [WORD_W:0] RECIP10       = 33'd6871947674;
  localparam int              RECIP10_SHIFT = 36;
  localparam int              FRAC_W        = 29;

endpackage

FILE: hw/rtl/momentum_sgd_weight_updater_unit.sv
// Momentum SGD weight updater: an item passes stages 1, 2 and 3 and then the result register.
// Throughput one item per cycle when the output does not stall; a step or load whose index
// is still in flight in the three pipeline stages holds s_axis_tready low
// (memory read-modify-write); epoch-end and start items update the rate in stage 1 and never do.
// rst (sync, active high) clears pipeline valids, rate, previous error and config registers;
// the weight and update memories are not cleared and hold nothing until loaded.
module momentum_sgd_weight_updater_unit (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [11:0] weight_index, [43:12] gradient_value, [75:44] load_value,
  // [107:76] epoch_error, [111:108] zero
  input  logic [msgd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] op
  input  logic [msgd_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [11:0] index_out, [43:12] new_weight, [75:44] new_update,
  // [107:76] rate_out, [111:108] zero
  output logic [msgd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] rate_was_cut, [1] saturated
  output logic [msgd_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [msgd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [msgd_pkg::WORD_W-1:0]       cfg_data
);
  import msgd_pkg::*;

  localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

  // saturate to signed 32 bits, clip flag on top
  function automatic logic [WORD_W:0] sat_word(input logic signed [39:0] x);
    logic [WORD_W:0] r;
    if (x > SAT_HI) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < SAT_LO) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[WORD_W-1:0]};
    end
    return r;
  endfunction

  // configuration and rate state
  logic [WORD_W-1:0] initial_rate;
  logic [WORD_W-1:0] decrease_factor;
  logic [WORD_W-1:0] momentum_factor;
  logic [WORD_W:0]   nd;
  logic [WORD_W:0]   fup;
  logic [WORD_W:0]   fup_next;
  logic [65:0]       q_prod;
  logic [WORD_W-1:0] current_rate;
  logic [WORD_W-1:0] rate_next;
  logic [WORD_W-1:0] previous_error;
  logic [WORD_W-1:0] prev_error_next;

  // memories
  logic [WORD_W-1:0] weight_mem [NUM_WEIGHTS];
  logic [WORD_W-1:0] update_mem [NUM_WEIGHTS];
  logic signed [WORD_W-1:0] rd_weight;
  logic signed [WORD_W-1:0] rd_update;
  logic              mem_we;

  // handshake and stage control
  logic s1_valid, s2_valid, s3_valid, out_valid;
  logic out_free, s3_go, s2_go, s1_go;
  logic accept, hazard;

  // input fields
  op_t                      in_op;
  logic [INDEX_W-1:0]       in_idx;
  logic [ADDR_W-1:0]        in_addr;
  logic                     in_wr;

  // stage 1 payload
  op_t                      s1_op;
  logic [INDEX_W-1:0]       s1_idx;
  logic                     s1_wr;
  logic signed [WORD_W-1:0] s1_grad;
  logic signed [WORD_W-1:0] s1_load;
  logic [WORD_W-1:0]        s1_err;
  logic signed [63:0]       p1_c;
  logic signed [63:0]       p2_c;
  logic                     rise;
  logic [WORD_W:0]          mult_f;
  logic [64:0]              rate_prod;
  logic [64:0]              rate_rnd;
  logic                     s1_cut, s1_clip;

  // stage 2 payload
  op_t                      s2_op;
  logic [INDEX_W-1:0]       s2_idx;
  logic                     s2_wr;
  logic signed [63:0]       s2_p1;
  logic signed [63:0]       s2_p2;
  logic signed [WORD_W-1:0] s2_weight;
  logic signed [WORD_W-1:0] s2_load;
  logic [WORD_W-1:0]        s2_rate;
  logic                     s2_cut, s2_clip;
  logic signed [65:0]       a1;
  logic signed [37:0]       t1;
  logic signed [64:0]       a2;
  logic signed [32:0]       t2;
  logic signed [39:0]       usum;
  logic [WORD_W:0]          usat;
  logic signed [WORD_W-1:0] upd_c;
  logic                     uclip_c;

  // stage 3 payload
  op_t                      s3_op;
  logic [INDEX_W-1:0]       s3_idx;
  logic                     s3_wr;
  logic signed [WORD_W-1:0] s3_upd;
  logic signed [WORD_W-1:0] s3_weight;
  logic signed [WORD_W-1:0] s3_load;
  logic [WORD_W-1:0]        s3_rate;
  logic                     s3_cut, s3_clip;
  logic signed [33:0]       wsum;
  logic [WORD_W:0]          wsat;
  logic [ADDR_W-1:0]        s3_addr;
  logic [INDEX_W-1:0]       out_idx_c;
  logic [WORD_W-1:0]        out_weight_c;
  logic                     clip_c;

  // result register
  logic [INDEX_W-1:0]       out_idx;
  logic [WORD_W-1:0]        out_weight;
  logic [WORD_W-1:0]        out_update;
  logic [WORD_W-1:0]        out_rate;
  logic                     out_cut, out_clip;

  // input unpacking
  assign in_op   = op_t'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[IN_IDX_LSB +: INDEX_W];
  assign in_addr = ADDR_W'(in_idx);
  assign in_wr   = ((in_op == OP_STEP) || (in_op == OP_LOAD)) &&
                   (32'(in_idx) < 32'(NUM_WEIGHTS));

  // stage advance: each stage moves when the one after it has room
  assign out_free = !out_valid || m_axis_tready;
  assign s3_go    = !s3_valid || out_free;
  assign s2_go    = !s2_valid || s3_go;
  assign s1_go    = !s1_valid || s2_go;

  // same-address write still in flight blocks the read of the next item
  assign hazard = in_wr && (
                  (s1_valid && s1_wr && (ADDR_W'(s1_idx) == in_addr)) ||
                  (s2_valid && s2_wr && (ADDR_W'(s2_idx) == in_addr)) ||
                  (s3_valid && s3_wr && (ADDR_W'(s3_idx) == in_addr)));

  assign s_axis_tready = s1_go && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // growth factor from the registered numerator
  assign q_prod   = 66'(nd) * 66'(RECIP10);
  assign fup_next = {1'b1, 32'(q_prod[RECIP10_SHIFT +: FRAC_W])};

  // stage 1: products and the rate update
  assign p1_c      = $signed({1'b0, current_rate}) * s1_grad;
  assign p2_c      = $signed({1'b0, momentum_factor}) * rd_update;
  assign rise      = s1_err > previous_error;
  assign mult_f    = rise ? {1'b0, decrease_factor} : fup;
  assign rate_prod = 65'(current_rate) * 65'(mult_f);
  assign rate_rnd  = rate_prod + 65'h0_8000_0000;

  always_comb begin
    rate_next       = current_rate;
    prev_error_next = previous_error;
    s1_cut          = 1'b0;
    s1_clip         = 1'b0;
    case (s1_op)
      OP_START: begin
        rate_next       = initial_rate;
        prev_error_next = ERROR_START;
      end
      OP_EPOCH: begin
        s1_cut          = rise;
        s1_clip         = rate_rnd[64];
        rate_next       = rate_rnd[64] ? '1 : rate_rnd[63:32];
        prev_error_next = s1_err;
      end
      default: begin
        rate_next = current_rate;
      end
    endcase
  end

  // stage 2: round both terms, sum and saturate the update
  assign a1   = 66'sd134217728 - 66'(s2_p1);
  assign t1   = a1[65:28];
  assign a2   = 65'(s2_p2) + 65'sd2147483648;
  assign t2   = a2[64:32];
  assign usum = 40'(t1) + 40'(t2);
  assign usat = sat_word(usum);

  always_comb begin
    if (s2_wr && (s2_op == OP_STEP)) begin
      upd_c   = usat[WORD_W-1:0];
      uclip_c = usat[WORD_W];
    end else begin
      upd_c   = '0;
      uclip_c = 1'b0;
    end
  end

  // stage 3: new weight and result fields
  assign wsum    = 34'(s3_weight) + 34'(s3_upd);
  assign wsat    = sat_word(40'(wsum));
  assign s3_addr = ADDR_W'(s3_idx);
  assign mem_we  = out_free && s3_valid && s3_wr;

  always_comb begin
    out_idx_c    = '0;
    out_weight_c = '0;
    clip_c       = s3_clip;
    case (s3_op)
      OP_STEP: begin
        out_idx_c = s3_idx;
        if (s3_wr) begin
          out_weight_c = wsat[WORD_W-1:0];
          clip_c       = s3_clip || wsat[WORD_W];
        end
      end
      OP_LOAD: begin
        out_idx_c = s3_idx;
        if (s3_wr) begin
          out_weight_c = s3_load;
        end
      end
      default: begin
        out_idx_c = '0;
      end
    endcase
  end

  // control state, rate state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      s3_valid        <= 1'b0;
      out_valid       <= 1'b0;
      current_rate    <= RATE_RESET;
      previous_error  <= ERROR_START;
      initial_rate    <= RATE_RESET;
      decrease_factor <= DECR_RESET;
      momentum_factor <= MOMENTUM_RESET;
      nd              <= ND_RESET;
      fup             <= FUP_RESET;
    end else begin
      if (s1_go) begin
        s1_valid <= accept;
      end
      if (s2_go) begin
        s2_valid <= s1_valid;
      end
      if (s3_go) begin
        s3_valid <= s2_valid;
      end
      if (out_free) begin
        out_valid <= s3_valid;
      end
      if (s1_valid && s2_go) begin
        current_rate   <= rate_next;
        previous_error <= prev_error_next;
      end
      fup <= fup_next;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_INIT_RATE: initial_rate <= cfg_data;
          CFG_DECREASE: begin
            decrease_factor <= cfg_data;
            nd              <= 33'h1_0000_0000 - {1'b0, cfg_data} + 33'd5;
          end
          CFG_MOMENTUM:  momentum_factor <= cfg_data;
          default: begin
            initial_rate <= initial_rate;
          end
        endcase
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= in_op;
      s1_idx  <= in_idx;
      s1_wr   <= in_wr;
      s1_grad <= s_axis_tdata[IN_GRAD_LSB +: WORD_W];
      s1_load <= s_axis_tdata[IN_LOAD_LSB +: WORD_W];
      s1_err  <= s_axis_tdata[IN_ERR_LSB +: WORD_W];
    end
    if (s2_go) begin
      s2_op     <= s1_op;
      s2_idx    <= s1_idx;
      s2_wr     <= s1_wr;
      s2_p1     <= p1_c;
      s2_p2     <= p2_c;
      s2_weight <= rd_weight;
      s2_load   <= s1_load;
      s2_rate   <= rate_next;
      s2_cut    <= s1_cut;
      s2_clip   <= s1_clip;
    end
    if (s3_go) begin
      s3_op     <= s2_op;
      s3_idx    <= s2_idx;
      s3_wr     <= s2_wr;
      s3_upd    <= upd_c;
      s3_weight <= s2_weight;
      s3_load   <= s2_load;
      s3_rate   <= s2_rate;
      s3_cut    <= s2_cut;
      s3_clip   <= s2_clip || uclip_c;
    end
    if (out_free) begin
      out_idx    <= out_idx_c;
      out_weight <= out_weight_c;
      out_update <= s3_upd;
      out_rate   <= s3_rate;
      out_cut    <= s3_cut;
      out_clip   <= clip_c;
    end
  end

  // weight memory: read on input transfer, write as the item leaves stage 3
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_weight <= weight_mem[in_addr];
    end
    if (mem_we) begin
      weight_mem[s3_addr] <= out_weight_c;
    end
  end

  // update memory, same access pattern
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_update <= update_mem[in_addr];
    end
    if (mem_we) begin
      update_mem[s3_addr] <= s3_upd;
    end
  end

  // result packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_rate, out_update, out_weight, out_idx};
  assign m_axis_tuser  = {out_clip, out_cut};

endmodule

FILE: hw/rtl/msgd_checker.sv
// port-level checks for the momentum sgd weight updater, bound to the top level
// depends on msgd_pkg and the assertion macro header
`include "momentum_sgd_weight_updater_unit_defines.svh"

module msgd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [msgd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [msgd_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import msgd_pkg::*;

  logic res_cut;
  logic res_sat;
  logic res_no_weight;

  // result fields
  assign res_cut       = m_axis_tvalid && m_axis_tuser[USER_CUT_BIT];
  assign res_sat       = m_axis_tuser[USER_SAT_BIT];
  assign res_no_weight = (m_axis_tdata[OUT_IDX_LSB +: INDEX_W] == '0) &&
                         (m_axis_tdata[OUT_WEIGHT_LSB +: WORD_W] == '0) &&
                         (m_axis_tdata[OUT_UPDATE_LSB +: WORD_W] == '0);

  // a pending result stays until its transfer
  `MSGD_ASSERT_NEXT(a_hold_valid, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped before transfer")

  // reset empties the output register
  `MSGD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid, "result valid right after reset")

  // a rate cut multiplies by a fraction and cannot clip
  `MSGD_ASSERT_IMPLIES(a_cut_no_clip, clk, rst, res_cut, !res_sat, "rate cut reported as saturated")

  // a rate cut comes from an epoch end that touches no weight
  `MSGD_ASSERT_IMPLIES(a_cut_no_weight, clk, rst, res_cut, res_no_weight, "rate cut with weight fields set")

endmodule

bind momentum_sgd_weight_updater_unit msgd_checker u_msgd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
